// ===== rtl/core/cha_pkg.sv =====
// Shared constants, table and payload widths for the compass heading block.
`default_nettype none
package cha_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int STEP_COUNT   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int STEP_W       = $clog2(ATAN_LEN);

    localparam int RAW_W        = 16;
    localparam int DEC_W        = 15;
    localparam int HEAD_W       = 17;
    localparam int PRESCALE_SH  = 8;
    localparam int VEC_W        = 27;
    localparam int ANG_W        = 26;
    localparam int DEG_W        = ANG_W - PRESCALE_SH;
    localparam int DIFF_W       = HEAD_W + 2;
    localparam int TAB_W        = 22;

    localparam logic signed [DEC_W-1:0] DEC_RESET    = 15'sd290;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] ROUND_BIAS   = 26'sd128;

    localparam logic [TAB_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

endpackage
`default_nettype wire

// ===== rtl/core/cha_if.sv =====
// Valid/ready channel interfaces for magnetometer samples and heading results.
`default_nettype none
interface cha_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cha_pkg::RAW_W-1:0]      raw_x;
    logic signed [cha_pkg::RAW_W-1:0]      raw_y;
    logic signed [cha_pkg::RAW_W-1:0]      raw_z;

    modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface cha_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cha_pkg::HEAD_W-1:0]     heading;
    logic                                  valid_res;

    modport source (output valid, output heading, output valid_res, input ready);
    modport sink   (input valid, input heading, input valid_res, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/compass_heading_atan2.sv =====
// Compass heading top level: CORDIC vectoring atan2 with declination offset.
`default_nettype none
// Takes one magnetometer sample beat (raw_x, raw_y, raw_z) and returns one
// result beat: heading = atan2(raw_x, raw_y) in 1/256 degree minus the
// declination register, unwrapped, with valid_res low (heading 0) for an
// all-zero sample. A sample beat is taken only while idle: the accepting edge
// loads and pre-rotates it, STEP_COUNT micro-rotations then run one per step
// on the shared add/shift unit, and a final step rounds, subtracts the
// declination and loads the output register once it is free. No new sample is
// taken until the result is in the output register. A sample with x and y both
// zero skips the micro-rotations and goes straight to the final step. The
// output register holds a finished beat so the next sample can be taken while
// that beat waits; that sample then holds in its final step until the waiting
// beat is taken.
module compass_heading_atan2 (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 decl_wen,
    input  wire  [cha_pkg::DEC_W-1:0]           decl_wdata,
    cha_sample_if.sink                          samples,
    cha_result_if.source                        result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                               state_reg, state_next;
    logic [cha_pkg::STEP_W-1:0]               step_reg, step_next;
    logic signed [cha_pkg::VEC_W-1:0]         re_reg, re_next;
    logic signed [cha_pkg::VEC_W-1:0]         im_reg, im_next;
    logic signed [cha_pkg::ANG_W-1:0]         ang_reg, ang_next;
    logic                                     ok_reg, ok_next;
    logic signed [cha_pkg::DEC_W-1:0]         dec_reg;
    logic                                     out_valid_reg, out_valid_next;
    logic signed [cha_pkg::HEAD_W-1:0]        heading_reg, heading_next;
    logic                                     valid_res_reg, valid_res_next;

    logic                                     accept;
    logic                                     out_free;
    logic                                     xy_zero;
    logic signed [cha_pkg::VEC_W-1:0]         re_in, im_in;
    logic signed [cha_pkg::VEC_W-1:0]         dre, dim;
    logic signed [cha_pkg::ANG_W-1:0]         tab_val;
    logic signed [cha_pkg::ANG_W-1:0]         ang_rnd;
    logic signed [cha_pkg::DEG_W-1:0]         deg;
    logic signed [cha_pkg::DIFF_W-1:0]        diff;

    assign samples.ready    = (state_reg == ST_IDLE);
    assign accept           = samples.valid && samples.ready;
    assign out_free         = !out_valid_reg || result.ready;
    assign result.valid     = out_valid_reg;
    assign result.heading   = heading_reg;
    assign result.valid_res = valid_res_reg;

    assign xy_zero = (samples.raw_x == '0) && (samples.raw_y == '0);
    assign re_in   = {{(cha_pkg::VEC_W - cha_pkg::RAW_W - cha_pkg::PRESCALE_SH)
                      {samples.raw_y[cha_pkg::RAW_W-1]}},
                      samples.raw_y, {cha_pkg::PRESCALE_SH{1'b0}}};
    assign im_in   = {{(cha_pkg::VEC_W - cha_pkg::RAW_W - cha_pkg::PRESCALE_SH)
                      {samples.raw_x[cha_pkg::RAW_W-1]}},
                      samples.raw_x, {cha_pkg::PRESCALE_SH{1'b0}}};

    assign dre     = im_reg >>> step_reg;
    assign dim     = re_reg >>> step_reg;
    assign tab_val = $signed(cha_pkg::ANG_W'(cha_pkg::ATAN_TABLE[step_reg]));

    assign ang_rnd = ang_reg + cha_pkg::ROUND_BIAS;
    assign deg     = $signed(ang_rnd[cha_pkg::ANG_W-1:cha_pkg::PRESCALE_SH]);
    assign diff    = cha_pkg::DIFF_W'(deg) - cha_pkg::DIFF_W'(dec_reg);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        ang_next       = ang_reg;
        ok_next        = ok_reg;
        heading_next   = heading_reg;
        valid_res_next = valid_res_reg;
        out_valid_next = out_valid_reg && !result.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next = '0;
                    ok_next   = !xy_zero || (samples.raw_z != '0);
                    ang_next  = '0;
                    re_next   = re_in;
                    im_next   = im_in;
                    if (re_in[cha_pkg::VEC_W-1])
                    begin
                        if (!im_in[cha_pkg::VEC_W-1])
                        begin
                            re_next  = im_in;
                            im_next  = -re_in;
                            ang_next = cha_pkg::QUARTER_TURN;
                        end
                        else
                        begin
                            re_next  = -im_in;
                            im_next  = re_in;
                            ang_next = -cha_pkg::QUARTER_TURN;
                        end
                    end
                    state_next = xy_zero ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!im_reg[cha_pkg::VEC_W-1])
                begin
                    re_next  = re_reg + dre;
                    im_next  = im_reg - dim;
                    ang_next = ang_reg + tab_val;
                end
                else
                begin
                    re_next  = re_reg - dre;
                    im_next  = im_reg + dim;
                    ang_next = ang_reg - tab_val;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == cha_pkg::STEP_W'(cha_pkg::STEP_COUNT - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    valid_res_next = ok_reg;
                    heading_next   = ok_reg ? diff[cha_pkg::HEAD_W-1:0] : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            dec_reg       <= cha_pkg::DEC_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (decl_wen)
            begin
                dec_reg <= $signed(decl_wdata);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg        <= re_next;
        im_reg        <= im_next;
        ang_reg       <= ang_next;
        ok_reg        <= ok_next;
        heading_reg   <= heading_next;
        valid_res_reg <= valid_res_next;
    end

`ifndef NO_ASSERTIONS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.valid_res |-> result.heading == '0)
        else $error("invalid beat carries nonzero heading");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !samples.ready)
        else $error("sample taken while previous one in work");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> step_reg < cha_pkg::STEP_W'(cha_pkg::STEP_COUNT))
        else $error("CORDIC step counter out of range");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && out_free |=> result.valid && samples.ready)
        else $error("finished sample did not reach output register");
`endif

endmodule
`default_nettype wire
